@@ design/qe_pkg.sv @@
// ----------------------------------------------------------------------------
// qe_pkg
// Shared widths, item type, arctangent table and angle rounding for the
// quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package qe_pkg;

    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 6;

    localparam int ATAN_LEN = 24;
    localparam int NSTG     = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int ACC_FRAC = 24;
    localparam int ACC_W    = 34;
    localparam int VW       = 38;
    localparam int QW       = 34;
    localparam int SW       = 32;
    localparam int RW       = 31;
    localparam int RMW      = 61;
    localparam int TW       = 63;
    localparam int IN_W     = 16;
    localparam int PRD_W    = 32;
    localparam int ROLL_W   = 15;
    localparam int PITCH_W  = 14;
    localparam int YAW_W    = 15;

    localparam int      SH     = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam longint  RND    = longint'(1) << (SH - 1);
    localparam longint  LIM180 = longint'(180) << ANGLE_FRAC_BITS;
    localparam longint  LIM90  = longint'(90) << ANGLE_FRAC_BITS;
    localparam longint  ACC90  = longint'(90) << ACC_FRAC;
    localparam longint  ONE_Q30 = longint'(1) << 30;

    typedef struct packed {
        logic signed [QW-1:0] roll_n;
        logic signed [QW-1:0] roll_d;
        logic signed [QW-1:0] yaw_n;
        logic signed [QW-1:0] yaw_d;
        logic signed [SW-1:0] pitch_s;
        logic [RW-1:0]        pitch_c;
        logic                 sat;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_beat;

    function automatic logic signed [ACC_W-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        unique case (idx)
            5'd0:  v = ACC_W'(754974720);
            5'd1:  v = ACC_W'(445687602);
            5'd2:  v = ACC_W'(235489089);
            5'd3:  v = ACC_W'(119537938);
            5'd4:  v = ACC_W'(60000934);
            5'd5:  v = ACC_W'(30029717);
            5'd6:  v = ACC_W'(15018523);
            5'd7:  v = ACC_W'(7509720);
            5'd8:  v = ACC_W'(3754917);
            5'd9:  v = ACC_W'(1877466);
            5'd10: v = ACC_W'(938734);
            5'd11: v = ACC_W'(469367);
            5'd12: v = ACC_W'(234684);
            5'd13: v = ACC_W'(117342);
            5'd14: v = ACC_W'(58671);
            5'd15: v = ACC_W'(29335);
            5'd16: v = ACC_W'(14668);
            5'd17: v = ACC_W'(7334);
            5'd18: v = ACC_W'(3667);
            5'd19: v = ACC_W'(1833);
            5'd20: v = ACC_W'(917);
            5'd21: v = ACC_W'(458);
            5'd22: v = ACC_W'(229);
            5'd23: v = ACC_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

    // round half up to the output grid, then clamp to +-limit
    function automatic logic signed [ACC_W-1:0] to_angle(
        input logic signed [ACC_W-1:0] acc,
        input logic                    is_pitch
    );
        logic signed [ACC_W:0] t;
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] lim;
        t   = (ACC_W+1)'(acc) + (ACC_W+1)'(RND);
        v   = t >>> SH;
        lim = is_pitch ? (ACC_W+1)'(LIM90) : (ACC_W+1)'(LIM180);
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v[ACC_W-1:0];
    endfunction

endpackage

@@ design/qe_front.sv @@
// ----------------------------------------------------------------------------
// qe_front
// Forms the component products, the atan2 operands and the clamped pitch
// sine, then the pitch cosine through a one-bit-per-stage square root.
// ----------------------------------------------------------------------------
module qe_front import qe_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [IN_W-1:0] i_w,
    input  logic signed [IN_W-1:0] i_x,
    input  logic signed [IN_W-1:0] i_y,
    input  logic signed [IN_W-1:0] i_z,
    output t_beat                  o_beat
);

    logic signed [PRD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic                    r_a_v;
    t_item                   r_b_itm;
    logic                    r_b_v;

    logic [RMW-1:0] r_rem  [0:RW];
    logic [RW-1:0]  r_root [0:RW];
    t_item          r_itm  [0:RW];
    logic           r_v    [0:RW];

    t_item                   n_b_itm;
    logic signed [QW-1:0]    s_raw;
    logic signed [2*SW-1:0]  sq;
    logic [TW-1:0]           t_try [0:RW-1];

    always_ff @(posedge i_clk) begin
        r_wx <= i_w * i_x;
        r_yz <= i_y * i_z;
        r_xx <= i_x * i_x;
        r_yy <= i_y * i_y;
        r_wz <= i_w * i_z;
        r_xy <= i_x * i_y;
        r_zz <= i_z * i_z;
        r_wy <= i_w * i_y;
        r_zx <= i_z * i_x;
    end

    always_comb begin
        n_b_itm        = '0;
        n_b_itm.roll_n = (QW'(r_wx) + QW'(r_yz)) <<< 1;
        n_b_itm.roll_d = QW'(ONE_Q30) - ((QW'(r_xx) + QW'(r_yy)) <<< 1);
        n_b_itm.yaw_n  = (QW'(r_wz) + QW'(r_xy)) <<< 1;
        n_b_itm.yaw_d  = QW'(ONE_Q30) - ((QW'(r_yy) + QW'(r_zz)) <<< 1);
        s_raw          = (QW'(r_wy) - QW'(r_zx)) <<< 1;
        priority if (s_raw > QW'(ONE_Q30)) begin
            n_b_itm.pitch_s = SW'(ONE_Q30);
            n_b_itm.sat     = 1'b1;
        end else if (s_raw < -QW'(ONE_Q30)) begin
            n_b_itm.pitch_s = -SW'(ONE_Q30);
            n_b_itm.sat     = 1'b1;
        end else begin
            n_b_itm.pitch_s = s_raw[SW-1:0];
            n_b_itm.sat     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_itm <= n_b_itm;
    end

    assign sq = r_b_itm.pitch_s * r_b_itm.pitch_s;

    always_comb begin
        for (int j = 0; j < RW; j++) begin
            t_try[j] = (TW'(r_root[j]) << (RW - j)) + (TW'(1) << (2 * (RW - 1 - j)));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= (RMW'(1) << (RMW - 1)) - sq[RMW-1:0];
        r_root[0] <= '0;
        r_itm[0]  <= r_b_itm;
        for (int j = 0; j < RW; j++) begin
            r_itm[j+1] <= r_itm[j];
            if (TW'(r_rem[j]) >= t_try[j]) begin
                r_rem[j+1]  <= r_rem[j] - t_try[j][RMW-1:0];
                r_root[j+1] <= r_root[j] | (RW'(1) << (RW - 1 - j));
            end else begin
                r_rem[j+1]  <= r_rem[j];
                r_root[j+1] <= r_root[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            for (int j = 0; j <= RW; j++) begin
                r_v[j] <= 1'b0;
            end
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_v[0] <= r_b_v;
            for (int j = 0; j < RW; j++) begin
                r_v[j+1] <= r_v[j];
            end
        end
    end

    always_comb begin
        o_beat              = '0;
        o_beat.valid        = r_v[RW];
        o_beat.item         = r_itm[RW];
        o_beat.item.pitch_c = r_root[RW];
    end

endmodule

@@ design/qe_fifo.sv @@
// ----------------------------------------------------------------------------
// qe_fifo
// Two-entry queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module qe_fifo import qe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_beat i_beat,
    output t_beat o_beat,
    output logic  o_full
);

    t_item      r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic push;
    logic pop;

    assign o_full = (r_cnt == 2'd2);
    assign push   = i_beat.valid && !o_full;
    assign pop    = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_beat.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_beat.valid = pop;
    assign o_beat.item  = r_mem[r_rp];

endmodule

@@ design/qe_cordic.sv @@
// ----------------------------------------------------------------------------
// qe_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in degrees Q24, one quadrant
// stage then one micro-rotation per stage.
// ----------------------------------------------------------------------------
module qe_cordic import qe_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [QW-1:0]    i_y,
    input  logic signed [QW-1:0]    i_x,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [VW-1:0]    r_x   [0:NSTG];
    logic signed [VW-1:0]    r_y   [0:NSTG];
    logic signed [ACC_W-1:0] r_acc [0:NSTG];
    logic                    r_z   [0:NSTG];

    logic signed [VW-1:0] xe;
    logic signed [VW-1:0] ye;

    assign xe = VW'(i_x);
    assign ye = VW'(i_y);

    always_ff @(posedge i_clk) begin
        r_z[0] <= (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            if (i_y >= 0) begin
                r_x[0]   <= ye;
                r_y[0]   <= -xe;
                r_acc[0] <= ACC_W'(ACC90);
            end else begin
                r_x[0]   <= -ye;
                r_y[0]   <= xe;
                r_acc[0] <= -ACC_W'(ACC90);
            end
        end else begin
            r_x[0]   <= xe;
            r_y[0]   <= ye;
            r_acc[0] <= '0;
        end
        for (int i = 0; i < NSTG; i++) begin
            r_z[i+1] <= r_z[i];
            if (r_y[i] >= 0) begin
                r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] + atan_q24(5'(i));
            end else begin
                r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] - atan_q24(5'(i));
            end
        end
    end

    assign o_acc = r_z[NSTG] ? '0 : r_acc[NSTG];

endmodule

@@ design/qe_back.sv @@
// ----------------------------------------------------------------------------
// qe_back
// Three CORDIC pipelines for roll, pitch and yaw, then rounding, clamping
// and the result register.
// ----------------------------------------------------------------------------
module qe_back import qe_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_beat                     i_beat,
    output logic                      o_valid,
    output logic signed [ROLL_W-1:0]  o_roll,
    output logic signed [PITCH_W-1:0] o_pitch,
    output logic signed [YAW_W-1:0]   o_yaw,
    output logic                      o_sat
);

    logic                    r_v   [0:NSTG];
    logic                    r_sat [0:NSTG];
    logic                    r_valid;
    logic signed [ROLL_W-1:0]  r_roll;
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [YAW_W-1:0]   r_yaw;
    logic                      r_osat;

    logic signed [ACC_W-1:0] roll_acc, pitch_acc, yaw_acc;
    logic signed [ACC_W-1:0] roll_a, pitch_a, yaw_a;

    qe_cordic u_roll (
        .i_clk (i_clk),
        .i_y   (i_beat.item.roll_n),
        .i_x   (i_beat.item.roll_d),
        .o_acc (roll_acc)
    );

    qe_cordic u_pitch (
        .i_clk (i_clk),
        .i_y   (QW'(i_beat.item.pitch_s)),
        .i_x   (QW'({1'b0, i_beat.item.pitch_c})),
        .o_acc (pitch_acc)
    );

    qe_cordic u_yaw (
        .i_clk (i_clk),
        .i_y   (i_beat.item.yaw_n),
        .i_x   (i_beat.item.yaw_d),
        .o_acc (yaw_acc)
    );

    assign roll_a  = to_angle(roll_acc, 1'b0);
    assign pitch_a = to_angle(pitch_acc, 1'b1);
    assign yaw_a   = to_angle(yaw_acc, 1'b0);

    always_ff @(posedge i_clk) begin
        r_sat[0] <= i_beat.item.sat;
        for (int i = 0; i < NSTG; i++) begin
            r_sat[i+1] <= r_sat[i];
        end
        r_roll  <= roll_a[ROLL_W-1:0];
        r_pitch <= pitch_a[PITCH_W-1:0];
        r_yaw   <= yaw_a[YAW_W-1:0];
        r_osat  <= r_sat[NSTG];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NSTG; i++) begin
                r_v[i] <= 1'b0;
            end
            r_valid <= 1'b0;
        end else begin
            r_v[0] <= i_beat.valid;
            for (int i = 0; i < NSTG; i++) begin
                r_v[i+1] <= r_v[i];
            end
            r_valid <= r_v[NSTG];
        end
    end

    assign o_valid = r_valid;
    assign o_roll  = r_roll;
    assign o_pitch = r_pitch;
    assign o_yaw   = r_yaw;
    assign o_sat   = r_osat;

endmodule

@@ design/quaternion_to_euler_angles_top.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Unit quaternion (Q1.15) to ZYX roll, pitch, yaw in degrees times 64.
//
//   channel  | handshake           | beat
//   ---------+---------------------+------------------------------------
//   command  | start / busy        | i_quat_w, i_quat_x, i_quat_y, i_quat_z
//   result   | o_valid (strobe)    | o_roll_deg, o_pitch_deg, o_yaw_deg,
//            |                     | o_pitch_saturated
//
// One quaternion per cycle while busy is low; each result passes through
// the 31-stage square root and the CORDIC stage chain. Synchronous
// active-low reset clears all valid bits; no clearing pass. busy rises
// only if the mid queue fills, which the always-draining back pipeline
// prevents.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top import qe_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [IN_W-1:0]    i_quat_w,
    input  logic signed [IN_W-1:0]    i_quat_x,
    input  logic signed [IN_W-1:0]    i_quat_y,
    input  logic signed [IN_W-1:0]    i_quat_z,
    output logic                      o_valid,
    output logic signed [ROLL_W-1:0]  o_roll_deg,
    output logic signed [PITCH_W-1:0] o_pitch_deg,
    output logic signed [YAW_W-1:0]   o_yaw_deg,
    output logic                      o_pitch_saturated
);

    t_beat front_beat;
    t_beat back_beat;
    logic  full;

    qe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_beat  (front_beat)
    );

    qe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (front_beat),
        .o_beat  (back_beat),
        .o_full  (full)
    );

    qe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (back_beat),
        .o_valid (o_valid),
        .o_roll  (o_roll_deg),
        .o_pitch (o_pitch_deg),
        .o_yaw   (o_yaw_deg),
        .o_sat   (o_pitch_saturated)
    );

    assign busy = full;

endmodule

@@ design/qe_checker.sv @@
// ----------------------------------------------------------------------------
// qe_checker
// Port-level checks on the converter's result beats and its busy flag.
// ----------------------------------------------------------------------------
module qe_checker import qe_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      busy,
    input logic                      o_valid,
    input logic signed [ROLL_W-1:0]  o_roll_deg,
    input logic signed [PITCH_W-1:0] o_pitch_deg,
    input logic signed [YAW_W-1:0]   o_yaw_deg,
    input logic                      o_pitch_saturated
);

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |-> !busy)
        else $error("mid queue filled");

    a_sat_pole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pitch_saturated |->
            (o_pitch_deg == PITCH_W'(LIM90)) || (o_pitch_deg == -PITCH_W'(LIM90)))
        else $error("clamped pitch not at a pole");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_deg <= PITCH_W'(LIM90)) && (o_pitch_deg >= -PITCH_W'(LIM90)))
        else $error("pitch out of range");

    a_roll_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_deg <= ROLL_W'(LIM180)) && (o_roll_deg >= -ROLL_W'(LIM180))
            && (o_yaw_deg <= YAW_W'(LIM180)) && (o_yaw_deg >= -YAW_W'(LIM180)))
        else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_angles_top qe_checker u_qe_checker (.*);
